>>> rtl/greedy_shift_reduce_recognizer_unit_assert.svh
// Assertion macros for the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef GREEDY_SHIFT_REDUCE_RECOGNIZER_UNIT_ASSERT_SVH
`define GREEDY_SHIFT_REDUCE_RECOGNIZER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define GSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gsr assertion failed");

// The consequence must hold in the cycle after the condition.
`define GSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gsr assertion failed");

`endif

>>> rtl/gsr_pkg.sv
package gsr_pkg;

    localparam int GSR_STACK_DEPTH    = 32;
    localparam int GSR_RULE_COUNT     = 8;
    localparam int GSR_MAX_RHS        = 4;
    localparam int GSR_MAX_REDUCTIONS = 64;
    localparam int GSR_SYMBOL_BITS    = 6;

    // Rule word layout.
    localparam int NUM_RULES  = 8;
    localparam int RULE_IDX_W = 3;
    localparam int RULE_W     = 33;
    localparam int FIELD_W    = 6;
    localparam int LEN_W      = 3;
    localparam int LEN_LSB    = 6;
    localparam int RHS_LSB    = 9;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    typedef logic [RULE_W-1:0] t_rule_word;

    typedef struct packed {
        logic [5:0] symbol;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] reductions;
        logic [5:0] depth;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic reduce;
        logic clear;
    } t_stack_op;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len;
    } t_match;

endpackage

>>> rtl/gsr_stack.sv
module gsr_stack #(
    parameter int STACK_DEPTH = gsr_pkg::GSR_STACK_DEPTH,
    parameter int MAX_RHS     = gsr_pkg::GSR_MAX_RHS,
    parameter int SYMBOL_BITS = gsr_pkg::GSR_SYMBOL_BITS,
    parameter int TAPS        = (MAX_RHS > 2) ? MAX_RHS : 2,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gsr_pkg::t_stack_op                i_op,
    input  logic [SYMBOL_BITS-1:0]            i_sym,
    input  logic [SYMBOL_BITS-1:0]            i_lhs,
    input  logic [gsr_pkg::LEN_W-1:0]         i_len,
    output logic [TAPS-1:0][SYMBOL_BITS-1:0]  o_taps,
    output logic [CNT_W-1:0]                  o_count
);
    import gsr_pkg::*;

    // Entry 0 is always the top of the stack; the bottom marker sits at count - 1.
    logic [SYMBOL_BITS-1:0] r_stack [STACK_DEPTH];
    logic [SYMBOL_BITS-1:0] n_stack [STACK_DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    always_comb begin
        n_stack = r_stack;
        n_count = r_count;
        if (i_op.clear) begin
            n_stack[0] = '0;
            n_count    = CNT_W'(1);
        end else if (i_op.push) begin
            n_stack[0] = i_sym;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                n_stack[i] = r_stack[i-1];
            end
            n_count = r_count + CNT_W'(1);
        end else if (i_op.reduce) begin
            // A rule of length L pops L entries and pushes its left side,
            // so the entries below move up by L - 1 places.
            n_stack[0] = i_lhs;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                for (int l = 2; l <= MAX_RHS; l++) begin
                    if (i_len == LEN_W'(l)) begin
                        n_stack[i] = r_stack[(i + l - 1 < STACK_DEPTH) ? (i + l - 1)
                                                                        : (STACK_DEPTH - 1)];
                    end
                end
            end
            n_count = r_count - CNT_W'(i_len) + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 1; i < STACK_DEPTH; i++) begin
            r_stack[i] <= n_stack[i];
        end
        if (!i_rst_n) begin
            r_count    <= CNT_W'(1);
            r_stack[0] <= '0;
        end else begin
            r_count    <= n_count;
            r_stack[0] <= n_stack[0];
        end
    end

    for (genvar k = 0; k < TAPS; k++) begin : g_taps
        assign o_taps[k] = r_stack[k];
    end

    assign o_count = r_count;

endmodule

>>> rtl/gsr_match.sv
module gsr_match #(
    parameter int MAX_RHS     = gsr_pkg::GSR_MAX_RHS,
    parameter int SYMBOL_BITS = gsr_pkg::GSR_SYMBOL_BITS,
    parameter int TAPS        = (MAX_RHS > 2) ? MAX_RHS : 2,
    parameter int CNT_W       = $clog2(gsr_pkg::GSR_STACK_DEPTH + 1)
) (
    input  gsr_pkg::t_rule_word              i_rule,
    input  logic [TAPS-1:0][SYMBOL_BITS-1:0] i_taps,
    input  logic [CNT_W-1:0]                 i_count,
    output gsr_pkg::t_match                  o_match,
    output logic [SYMBOL_BITS-1:0]           o_lhs
);
    import gsr_pkg::*;

    logic [LEN_W-1:0]       len;
    logic [SYMBOL_BITS-1:0] rhs   [MAX_RHS];
    logic [MAX_RHS:1]       hit_l;

    // One rule against the stack top; the sequencer steps it through the rule list.
    always_comb begin
        len = i_rule[LEN_LSB +: LEN_W];
        for (int j = 0; j < MAX_RHS; j++) begin
            rhs[j] = i_rule[RHS_LSB + FIELD_W * j +: SYMBOL_BITS];
        end
        for (int l = 1; l <= MAX_RHS; l++) begin
            hit_l[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (i_taps[l-1-j] != rhs[j]) begin
                    hit_l[l] = 1'b0;
                end
            end
        end
        o_match.len = len;
        o_match.hit = 1'b0;
        // Lengths of zero or above the limit never hit.
        for (int l = 1; l <= MAX_RHS; l++) begin
            if (len == LEN_W'(l) && i_count >= CNT_W'(l)) begin
                o_match.hit = hit_l[l];
            end
        end
    end

    assign o_lhs = i_rule[SYMBOL_BITS-1:0];

endmodule

>>> rtl/greedy_shift_reduce_recognizer_unit.sv
// Steps: S_IDLE accepts an item; S_MATCH tries the rules in order, back to rule 0 after each
//   reduction, using the single rule comparator that is stepped through the rule list;
//   S_DONE posts the result word once the output is free.
// A latched error or a full stack skips S_MATCH; the reduction limit skips the last scan.
// Throughput: one item at a time; the next item is taken once the result word is registered.
// Reset (synchronous, active low) clears the rules, the stack to the marker, and the error.
module greedy_shift_reduce_recognizer_unit #(
    parameter int STACK_DEPTH    = gsr_pkg::GSR_STACK_DEPTH,
    parameter int RULE_COUNT     = gsr_pkg::GSR_RULE_COUNT,
    parameter int MAX_RHS        = gsr_pkg::GSR_MAX_RHS,
    parameter int MAX_REDUCTIONS = gsr_pkg::GSR_MAX_REDUCTIONS,
    parameter int SYMBOL_BITS    = gsr_pkg::GSR_SYMBOL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gsr_pkg::RULE_IDX_W-1:0]   i_cfg_idx,
    input  logic [gsr_pkg::RULE_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gsr_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gsr_pkg::t_out_item               o_out_item
);
    import gsr_pkg::*;

    localparam int TAPS    = (MAX_RHS > 2) ? MAX_RHS : 2;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int RED_W   = $clog2(MAX_REDUCTIONS + 1);
    localparam int RULE_IW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state                           r_state, n_state;
    logic [RULE_IW-1:0]               r_rule, n_rule;
    logic [RED_W-1:0]                 r_red, n_red;
    logic                             r_err, n_err;
    logic                             r_last, n_last;
    logic                             r_out_valid, n_out_valid;
    t_out_item                        r_out_item, n_out_item;
    t_rule_word                       r_rules [NUM_RULES];

    t_stack_op                        op;
    t_match                           match;
    t_rule_word                       rule_sel;
    logic [SYMBOL_BITS-1:0]           lhs;
    logic [SYMBOL_BITS-1:0]           sym_in;
    logic [TAPS-1:0][SYMBOL_BITS-1:0] taps;
    logic [CNT_W-1:0]                 stack_count;
    logic                             full;
    logic                             out_free;
    logic                             accept_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                r_rules[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_rules[i_cfg_idx] <= i_cfg_data;
        end
    end

    gsr_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_RHS     (MAX_RHS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .TAPS        (TAPS),
        .CNT_W       (CNT_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_sym   (sym_in),
        .i_lhs   (lhs),
        .i_len   (match.len),
        .o_taps  (taps),
        .o_count (stack_count)
    );

    assign rule_sel = r_rules[RULE_IDX_W'(r_rule)];

    gsr_match #(
        .MAX_RHS     (MAX_RHS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .TAPS        (TAPS),
        .CNT_W       (CNT_W)
    ) u_match (
        .i_rule  (rule_sel),
        .i_taps  (taps),
        .i_count (stack_count),
        .o_match (match),
        .o_lhs   (lhs)
    );

    assign sym_in     = i_in_item.symbol[SYMBOL_BITS-1:0];
    assign full       = (stack_count >= CNT_W'(STACK_DEPTH));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    // Accept needs exactly the bottom marker under the left side of rule 0.
    assign accept_ok  = (stack_count == CNT_W'(2)) && (taps[1] == '0)
                        && (taps[0] == r_rules[0][SYMBOL_BITS-1:0]);

    always_comb begin
        n_state     = r_state;
        n_rule      = r_rule;
        n_red       = r_red;
        n_err       = r_err;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        op          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_in_item.last;
                    n_red  = '0;
                    n_rule = '0;
                    if (r_err) begin
                        n_state = S_DONE;
                    end else if (sym_in != '0 && full) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        op.push = (sym_in != '0);
                        n_state = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                if (match.hit) begin
                    // A hit past the limit still reduces, then latches the error.
                    op.reduce = 1'b1;
                    n_rule    = '0;
                    if (r_red == RED_W'(MAX_REDUCTIONS)) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_red = r_red + RED_W'(1);
                    end
                end else if (r_rule == RULE_IW'(RULE_COUNT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_rule = r_rule + RULE_IW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.reductions = 7'(r_red);
                    n_out_item.depth      = 6'(stack_count);
                    if (r_err) begin
                        n_out_item.status = ST_ERROR;
                    end else if (r_last) begin
                        n_out_item.status = accept_ok ? ST_ACCEPT : ST_REJECT;
                    end else begin
                        n_out_item.status = ST_PENDING;
                    end
                    if (r_last) begin
                        op.clear = 1'b1;
                        n_err    = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_rule      <= '0;
            r_red       <= '0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_rule      <= n_rule;
            r_red       <= n_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/gsr_checker.sv
`include "greedy_shift_reduce_recognizer_unit_assert.svh"

module gsr_checker #(
    parameter int MAX_REDUCTIONS = gsr_pkg::GSR_MAX_REDUCTIONS
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gsr_pkg::t_out_item o_out_item
);
    import gsr_pkg::*;

    // The block works on one word at a time, so it must be busy right after taking one.
    `GSR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `GSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `GSR_ASSERT_IMPL(a_red_bound, i_clk, i_rst_n, o_out_valid, o_out_item.reductions <= 7'(MAX_REDUCTIONS))
    `GSR_ASSERT_IMPL(a_accept_depth, i_clk, i_rst_n, o_out_valid && o_out_item.status == ST_ACCEPT, o_out_item.depth == 6'd2)

endmodule

bind greedy_shift_reduce_recognizer_unit gsr_checker #(
    .MAX_REDUCTIONS (MAX_REDUCTIONS)
) u_gsr_checker (.*);

>>> dv/greedy_shift_reduce_recognizer_unit_tb.sv
`timescale 1ns / 1ps

module greedy_shift_reduce_recognizer_unit_tb;
    import gsr_pkg::*;

    typedef logic [FIELD_W-1:0] t_sym;

    localparam int CYCLE_LIMIT  = 5_000_000;
    // Slowest item: every rule tried on each of the reductions plus the one over the limit.
    localparam int DRAIN_CYCLES = 2 + GSR_RULE_COUNT + (GSR_MAX_REDUCTIONS + 1) * GSR_RULE_COUNT;

    // Token codes of the expression grammar and of the other directed cases.
    localparam t_sym SYM_END    = 6'd0;
    localparam t_sym SYM_ID     = 6'd1;
    localparam t_sym SYM_PLUS   = 6'd2;
    localparam t_sym SYM_LP     = 6'd4;
    localparam t_sym SYM_RP     = 6'd5;
    localparam t_sym SYM_E      = 6'd10;
    localparam t_sym SYM_T      = 6'd11;
    localparam t_sym SYM_LOOP_A = 6'd20;
    localparam t_sym SYM_LOOP_B = 6'd21;
    localparam t_sym SYM_PAD    = 6'd30;
    localparam t_sym SYM_HEAD   = 6'd40;
    localparam t_sym SYM_BASE   = 6'd50;
    localparam t_sym SYM_LONG   = 6'd61;
    localparam t_sym SYM_TOP    = 6'd63;

    localparam int PICK_GRAMMAR = 0;
    localparam int PICK_WIDE    = 1;
    localparam int PICK_SMALL   = 2;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [RULE_IDX_W-1:0] i_cfg_idx  = '0;
    logic [RULE_W-1:0]     i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    greedy_shift_reduce_recognizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_in_item   pending_words[$];
    t_out_item  expected_words[$];
    t_rule_word rule_plan [NUM_RULES];
    int         queued;
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         gap_left    = 0;
    int         hold_left   = 0;
    bit         steady_in   = 1'b0;
    bit         steady_out  = 1'b0;

    t_sym grammar_syms [10] = '{SYM_ID, SYM_PLUS, SYM_LP, SYM_RP, SYM_E, SYM_T,
                                SYM_LOOP_A, SYM_LOOP_B, SYM_PAD, SYM_BASE};

    // Own copy of the recognizer state.
    t_rule_word rules_mdl [NUM_RULES];
    t_sym       stack_mdl [GSR_STACK_DEPTH] = '{default: '0};
    int         depth_mdl = 1;
    bit         err_mdl   = 1'b0;

    function automatic t_rule_word make_rule(input t_sym lhs, input logic [LEN_W-1:0] len,
                                             input t_sym s0, input t_sym s1,
                                             input t_sym s2, input t_sym s3);
        return {s3, s2, s1, s0, len, lhs};
    endfunction

    function automatic void clear_stack_model();
        foreach (stack_mdl[k])
            stack_mdl[k] = '0;
        depth_mdl = 1;
    endfunction

    // Replaces the stack top by the left side of the first matching rule.
    function automatic bit try_reduce();
        int len;
        int pos;
        bit hit;
        for (int r = 0; r < GSR_RULE_COUNT; r++) begin
            len = int'(rules_mdl[r][LEN_LSB +: LEN_W]);
            if (len != 0 && len <= GSR_MAX_RHS && depth_mdl >= len) begin
                hit = 1'b1;
                for (int j = 0; j < len; j++) begin
                    pos = depth_mdl - len + j;
                    if (stack_mdl[pos] != rules_mdl[r][RHS_LSB + FIELD_W * j +: FIELD_W])
                        hit = 1'b0;
                end
                if (hit) begin
                    depth_mdl = depth_mdl - len;
                    stack_mdl[depth_mdl] = rules_mdl[r][FIELD_W-1:0];
                    depth_mdl++;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out_item recognize_word(input t_in_item w);
        t_out_item res;
        int        n;
        bit        more;
        n = 0;
        if (!err_mdl) begin
            if (w.symbol != SYM_END) begin
                if (depth_mdl >= GSR_STACK_DEPTH) begin
                    err_mdl = 1'b1;
                end else begin
                    stack_mdl[depth_mdl] = w.symbol;
                    depth_mdl++;
                end
            end
            if (!err_mdl) begin
                more = 1'b1;
                while (more && n < GSR_MAX_REDUCTIONS) begin
                    more = try_reduce();
                    if (more)
                        n++;
                end
                // One more match past the limit means an endless rule cycle.
                if (more) begin
                    if (try_reduce())
                        err_mdl = 1'b1;
                end
            end
        end
        res.depth      = 6'(depth_mdl);
        res.reductions = 7'(n);
        if (err_mdl)
            res.status = ST_ERROR;
        else if (!w.last)
            res.status = ST_PENDING;
        else if (depth_mdl == 2 && stack_mdl[0] == SYM_END &&
                 stack_mdl[1] == rules_mdl[0][FIELD_W-1:0])
            res.status = ST_ACCEPT;
        else
            res.status = ST_REJECT;
        if (w.last) begin
            clear_stack_model();
            err_mdl = 1'b0;
        end
        return res;
    endfunction

    function automatic t_sym pick_symbol(input int kind);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return SYM_END;
        if (roll <= 2)
            return t_sym'($urandom_range(0, 63));
        case (kind)
            PICK_GRAMMAR: return grammar_syms[$urandom_range(0, 9)];
            PICK_WIDE:    return (roll < 6) ? SYM_TOP : t_sym'($urandom_range(1, 63));
            default:      return t_sym'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic queue_word(input t_sym sym, input bit last);
        t_in_item w;
        w.symbol = sym;
        w.last   = last;
        pending_words = {pending_words, w};
        queued++;
    endtask

    task automatic queue_run(input int kind, input int len);
        for (int k = 0; k < len; k++)
            queue_word(pick_symbol(kind), k == len - 1);
    endtask

    // A sum of identifiers with nested parentheses; optionally one token is damaged.
    task automatic queue_sentence(input bit broken);
        t_sym toks[$];
        int   lvl;
        int   at;
        bit   done;
        bit   use_end;
        lvl  = 0;
        done = 1'b0;
        while (!done) begin
            while (lvl < 4 && $urandom_range(0, 3) == 0) begin
                toks = {toks, SYM_LP};
                lvl++;
            end
            toks = {toks, SYM_ID};
            while (lvl > 0 && $urandom_range(0, 1) == 0) begin
                toks = {toks, SYM_RP};
                lvl--;
            end
            if (toks.size() < 20 && $urandom_range(0, 2) != 0) begin
                toks = {toks, SYM_PLUS};
            end else begin
                while (lvl > 0) begin
                    toks = {toks, SYM_RP};
                    lvl--;
                end
                done = 1'b1;
            end
        end
        if (broken) begin
            at = $urandom_range(0, toks.size() - 1);
            if ($urandom_range(0, 1) == 0)
                toks.delete(at);
            else
                toks[at] = t_sym'($urandom_range(0, 63));
        end
        use_end = ($urandom_range(0, 2) == 0) || toks.size() == 0;
        foreach (toks[i]) begin
            if ($urandom_range(0, 15) == 0)
                queue_word(SYM_END, 1'b0);
            queue_word(toks[i], !use_end && i == toks.size() - 1);
        end
        if (use_end)
            queue_word(SYM_END, 1'b1);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic commit_rules();
        wait_idle();
        for (int r = 0; r < NUM_RULES; r++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= RULE_IDX_W'(r);
            i_cfg_data <= rule_plan[r];
            rules_mdl[r] = rule_plan[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic plan_expression_rules();
        rule_plan[0] = make_rule(SYM_E, 3'd3, SYM_E, SYM_PLUS, SYM_T, SYM_END);
        rule_plan[1] = make_rule(SYM_E, 3'd1, SYM_T, SYM_END, SYM_END, SYM_END);
        rule_plan[2] = make_rule(SYM_T, 3'd1, SYM_ID, SYM_END, SYM_END, SYM_END);
        rule_plan[3] = make_rule(SYM_T, 3'd3, SYM_LP, SYM_E, SYM_RP, SYM_END);
        // Right side longer than the comparator takes: must never fire.
        rule_plan[4] = make_rule(SYM_LONG, 3'd5, SYM_PAD, SYM_PAD, SYM_PAD, SYM_PAD);
        // Matches the bottom marker and replaces it.
        rule_plan[5] = make_rule(SYM_HEAD, 3'd2, SYM_END, SYM_BASE, SYM_END, SYM_END);
        // Two unit rules that rewrite each other forever.
        rule_plan[6] = make_rule(SYM_LOOP_B, 3'd1, SYM_LOOP_A, SYM_END, SYM_END, SYM_END);
        rule_plan[7] = make_rule(SYM_LOOP_A, 3'd1, SYM_LOOP_B, SYM_END, SYM_END, SYM_END);
    endtask

    // Input side: one word in flight, a random gap drawn after each accepted word.
    always @(posedge i_clk) begin : drive_blk
        logic     show;
        t_in_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            show = i_in_valid;
            nxt  = i_in_item;
            if (i_in_valid && !o_in_stall) begin
                expected_words = {expected_words, recognize_word(i_in_item)};
                show = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    steady_in = !steady_in;
                gap_left = steady_in ? 0 : $urandom_range(0, 12);
            end
            if (!show) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    nxt  = pending_words.pop_front();
                    show = 1'b1;
                end
            end
            i_in_valid <= show;
            i_in_item  <= nxt;
        end
    end

    // Output side: each word is held off for a random number of valid cycles.
    always @(posedge i_clk) begin : watch_blk
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no word expected: %h", o_out_item);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                        mismatches++;
                    end
                    if (o_out_item.reductions !== want.reductions) begin
                        $error("reductions: expected %0d, got %0d",
                               want.reductions, o_out_item.reductions);
                        mismatches++;
                    end
                    if (o_out_item.depth !== want.depth) begin
                        $error("depth: expected %0d, got %0d", want.depth, o_out_item.depth);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    steady_out = !steady_out;
                hold_left = steady_out ? 0 : $urandom_range(0, 12);
            end else if (o_out_valid && hold_left > 0) begin
                hold_left--;
            end
            i_out_stall <= (hold_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("greedy_shift_reduce_recognizer_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int target;
        queued = 0;
        foreach (rules_mdl[r])
            rules_mdl[r] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rules as reset leaves them: nothing reduces, nothing can be accepted.
        queue_word(SYM_TOP, 1'b0);
        queue_word(SYM_END, 1'b1);
        queue_word(SYM_END, 1'b1);
        queue_word(6'd42, 1'b1);

        plan_expression_rules();
        commit_rules();
        // id + ( id + id ) is accepted.
        queue_word(SYM_ID, 1'b0);
        queue_word(SYM_PLUS, 1'b0);
        queue_word(SYM_LP, 1'b0);
        queue_word(SYM_ID, 1'b0);
        queue_word(SYM_PLUS, 1'b0);
        queue_word(SYM_ID, 1'b0);
        queue_word(SYM_RP, 1'b1);
        // A dangling plus is rejected at the end marker.
        queue_word(SYM_ID, 1'b0);
        queue_word(SYM_PLUS, 1'b0);
        queue_word(SYM_END, 1'b1);
        queue_word(SYM_BASE, 1'b0);
        queue_word(SYM_END, 1'b1);
        repeat (3) queue_word(SYM_PAD, 1'b0);
        queue_word(SYM_PAD, 1'b1);
        // The unit-rule cycle runs into the reduction limit; the error holds until last.
        queue_word(SYM_LOOP_A, 1'b0);
        queue_word(SYM_ID, 1'b0);
        queue_word(SYM_END, 1'b1);

        target = queued + 500;
        while (queued < target) begin
            case ($urandom_range(0, 9))
                8:       queue_sentence(1'b1);
                9:       queue_run(PICK_GRAMMAR, $urandom_range(1, 6));
                default: queue_sentence(1'b0);
            endcase
        end

        // Every rule unused; long runs overflow the stack.
        foreach (rule_plan[r])
            rule_plan[r] = '1;
        commit_rules();
        target = queued + 200;
        while (queued < target)
            queue_run(PICK_WIDE, ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40));

        repeat (3) begin
            for (int r = 0; r < NUM_RULES; r++) begin
                if ($urandom_range(0, 7) == 0)
                    rule_plan[r] = t_rule_word'({$urandom, $urandom});
                else
                    rule_plan[r] = make_rule(t_sym'($urandom_range(1, 6)),
                        LEN_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                          : $urandom_range(0, 7)),
                        t_sym'($urandom_range(0, 6)), t_sym'($urandom_range(0, 6)),
                        t_sym'($urandom_range(0, 6)), t_sym'($urandom_range(0, 6)));
            end
            commit_rules();
            target = queued + 180;
            while (queued < target)
                queue_run(PICK_SMALL, $urandom_range(1, 12));
        end

        foreach (rule_plan[r])
            rule_plan[r] = '0;
        commit_rules();
        target = queued + 60;
        while (queued < target)
            queue_run(PICK_GRAMMAR, $urandom_range(1, 8));

        plan_expression_rules();
        commit_rules();
        target = queued + 100;
        while (queued < target)
            queue_sentence($urandom_range(0, 4) == 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("greedy_shift_reduce_recognizer_unit regression: pass");
        else
            $display("greedy_shift_reduce_recognizer_unit regression: fail");
        $finish;
    end

endmodule
